// File: hdl/tts_pkg.sv
package tts_pkg;

   // Default tree shape: 1 << DEF_LEVELS leaves, times of DEF_TIME_BITS bits.
   localparam int DEF_LEVELS    = 10;
   localparam int DEF_TIME_BITS = 48;

   typedef enum logic {
      REQ_SET       = 1'b0,
      REQ_RESET_ALL = 1'b1
   } req_code_type;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

endpackage

// File: hdl/tts_channels.sv
// Request channel: one scheduler operation per item.
interface tts_req_if import tts_pkg::*; #(
   parameter int LEVELS    = DEF_LEVELS,
   parameter int TIME_BITS = DEF_TIME_BITS
);
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [LEVELS-1:0]    leaf_index;
   logic [TIME_BITS-1:0] new_time;

   modport source (output valid, req_type, leaf_index, new_time, input ready);
   modport sink   (input valid, req_type, leaf_index, new_time, output ready);
endinterface

// Response channel: the earliest pending event after each operation.
interface tts_rsp_if import tts_pkg::*; #(
   parameter int LEVELS    = DEF_LEVELS,
   parameter int TIME_BITS = DEF_TIME_BITS
);
   logic                 valid;
   logic                 ready;
   logic [LEVELS-1:0]    earliest_leaf;
   logic [TIME_BITS-1:0] earliest_time;
   logic                 none_pending;
   logic                 status;

   modport source (output valid, earliest_leaf, earliest_time, none_pending, status,
                   input ready);
   modport sink   (input valid, earliest_leaf, earliest_time, none_pending, status,
                   output ready);
endinterface

// Control register write channel, carrying the number of leaves in use.
interface tts_csr_if import tts_pkg::*; #(
   parameter int LEVELS = DEF_LEVELS
);
   logic              valid;
   logic              ready;
   logic [LEVELS:0]   active_count;

   modport source (output valid, active_count, input ready);
   modport sink   (input valid, active_count, output ready);
endinterface

// File: hdl/tts_node_store.sv
// Node storage of the tournament tree: one write port and two registered read ports.
module tts_node_store import tts_pkg::*; #(
   parameter int ADDR_BITS = DEF_LEVELS + 1,
   parameter int DATA_BITS = DEF_LEVELS + DEF_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_a_addr,
   output logic [DATA_BITS-1:0] rd_a_data,
   input  logic [ADDR_BITS-1:0] rd_b_addr,
   output logic [DATA_BITS-1:0] rd_b_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] node_mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_a_data_ff;
   logic [DATA_BITS-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data_ff <= node_mem_ff[rd_a_addr];
      rd_b_data_ff <= node_mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

// File: hdl/tournament_tree_event_scheduler_unit.sv
// Tournament-tree event scheduler. The block keeps the next event time of each of
// 1 << LEVELS leaves in a min tournament tree held in one node memory (node 1 is the
// root, node n has children 2n and 2n+1, leaf i is node LEAVES + i), and every request
// item returns the leaf with the earliest time, that time, a none-pending flag and a
// status. A set item writes the leaf and then walks its path to the root with one
// shared compare unit, one level per cycle; the block takes no new item until the
// result of the walk is in the output register. A set on a leaf at or above
// active_count changes nothing, reports status 1, and skips the walk. A reset-all
// item and a write of active_count both sweep the leaves, one leaf per cycle, and then
// rebuild every internal node from the bottom up, reading both children on the memory's
// read ports and then writing the node. The same sweep and rebuild run once after reset
// as the clearing pass, during which no request item is taken; active_count writes
// are taken only when the block is idle. Ties go to the lower leaf index, and
// all-ones times mean never. Responses sit in an output register, so a finished result
// may wait for the consumer while the block already takes the next item.
module tournament_tree_event_scheduler_unit import tts_pkg::*; #(
   parameter int LEVELS    = DEF_LEVELS,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic   clock,
   input  logic   reset,
   tts_req_if.sink   req_ch,
   tts_rsp_if.source rsp_ch,
   tts_csr_if.sink   csr_ch
);

   localparam int LEAVES    = 1 << LEVELS;
   localparam int NODE_BITS = LEVELS + 1;
   localparam int WORD_BITS = LEVELS + TIME_BITS;
   localparam logic [TIME_BITS-1:0] NEVER     = {TIME_BITS{1'b1}};
   localparam logic [NODE_BITS-1:0] ROOT_NODE = NODE_BITS'(1);
   localparam logic [LEVELS-1:0]    LAST_LEAF = {LEVELS{1'b1}};
   localparam logic [LEVELS:0]      MAX_COUNT = (LEVELS + 1)'(LEAVES);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FILL  = 6'b000010,
      S_RB_RD = 6'b000100,
      S_RB_WR = 6'b001000,
      S_UPD   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   // Sequencer state.
   state_type            state_ff, state_in;
   logic [LEVELS:0]      active_ff, active_in;
   logic                 fill_all_ff, fill_all_in;
   logic                 rsp_due_ff, rsp_due_in;
   logic [LEVELS-1:0]    fill_idx_ff, fill_idx_in;
   logic [LEVELS-1:0]    node_ff, node_in;
   logic [NODE_BITS-1:0] path_ff, path_in;
   logic                 first_ff, first_in;
   logic                 prev_right_ff, prev_right_in;
   logic                 status_ff, status_in;

   // Payload registers.
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TIME_BITS-1:0] cur_time_ff, cur_time_in;
   logic [LEVELS-1:0]    cur_leaf_ff, cur_leaf_in;
   logic [TIME_BITS-1:0] root_time_ff, root_time_in;
   logic [LEVELS-1:0]    root_leaf_ff, root_leaf_in;

   // Response output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVELS-1:0]    rsp_leaf_ff, rsp_leaf_in;
   logic [TIME_BITS-1:0] rsp_time_ff, rsp_time_in;
   logic                 rsp_none_ff, rsp_none_in;
   logic                 rsp_status_ff, rsp_status_in;

   // Node memory ports.
   logic                 wr_en;
   logic [NODE_BITS-1:0] wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [NODE_BITS-1:0] rd_a_addr;
   logic [NODE_BITS-1:0] rd_b_addr;
   logic [WORD_BITS-1:0] rd_a_data;
   logic [WORD_BITS-1:0] rd_b_data;

   // Shared compare unit operands and result.
   logic [TIME_BITS-1:0] cmp_l_time, cmp_r_time, win_time;
   logic [LEVELS-1:0]    cmp_l_leaf, cmp_r_leaf, win_leaf;

   logic                 req_fire;
   logic                 csr_fire;
   logic                 rsp_free;
   logic                 set_ok;
   logic                 fill_active;
   logic [LEVELS:0]      csr_count;

   tts_node_store #(
      .ADDR_BITS (NODE_BITS),
      .DATA_BITS (WORD_BITS)
   ) u_node_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   // Configuration takes priority over a request that arrives in the same idle cycle.
   assign csr_ch.ready = (state_ff == S_IDLE);
   assign req_ch.ready = (state_ff == S_IDLE) && !csr_ch.valid;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // A set is carried out only on a leaf below the count of leaves in use.
   assign set_ok      = ({1'b0, req_ch.leaf_index} < active_ff);
   assign fill_active = ({1'b0, fill_idx_ff} < active_ff);
   assign csr_count   = (csr_ch.active_count > MAX_COUNT) ? MAX_COUNT : csr_ch.active_count;

   // The one compare unit. The left operand wins a tie, which keeps the lower leaf.
   always_comb begin
      cmp_l_time = rd_a_data[TIME_BITS-1:0];
      cmp_l_leaf = rd_a_data[WORD_BITS-1:TIME_BITS];
      cmp_r_time = rd_b_data[TIME_BITS-1:0];
      cmp_r_leaf = rd_b_data[WORD_BITS-1:TIME_BITS];
      if (state_ff == S_UPD) begin
         // On the update path the climbing winner meets its sibling, read on port A.
         if (prev_right_ff) begin
            cmp_r_time = cur_time_ff;
            cmp_r_leaf = cur_leaf_ff;
         end else begin
            cmp_l_time = cur_time_ff;
            cmp_l_leaf = cur_leaf_ff;
            cmp_r_time = rd_a_data[TIME_BITS-1:0];
            cmp_r_leaf = rd_a_data[WORD_BITS-1:TIME_BITS];
         end
      end
      if (cmp_l_time <= cmp_r_time) begin
         win_time = cmp_l_time;
         win_leaf = cmp_l_leaf;
      end else begin
         win_time = cmp_r_time;
         win_leaf = cmp_r_leaf;
      end
   end

   // Memory access for each sequencer step.
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_a_addr = '0;
      rd_b_addr = '0;
      unique case (state_ff)
         S_IDLE: begin
            // An accepted set writes its leaf right away.
            wr_en   = req_fire && (req_ch.req_type == REQ_SET) && set_ok && !csr_ch.valid;
            wr_addr = {1'b1, req_ch.leaf_index};
            wr_data = {req_ch.leaf_index, req_ch.new_time};
         end
         S_FILL: begin
            // Leaves at or above the count always hold never; a reset-all also loads the rest.
            wr_en   = fill_all_ff || !fill_active;
            wr_addr = {1'b1, fill_idx_ff};
            wr_data = {fill_idx_ff, fill_active ? time_ff : NEVER};
         end
         S_RB_RD: begin
            rd_a_addr = {node_ff, 1'b0};
            rd_b_addr = {node_ff, 1'b1};
         end
         S_RB_WR: begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, node_ff};
            wr_data = {win_leaf, win_time};
         end
         S_UPD: begin
            // Fetch the sibling of the current path node while the previous level
            // resolves into that node.
            rd_a_addr = path_ff ^ ROOT_NODE;
            wr_en     = !first_ff;
            wr_addr   = path_ff;
            wr_data   = {win_leaf, win_time};
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      fill_all_in   = fill_all_ff;
      rsp_due_in    = rsp_due_ff;
      fill_idx_in   = fill_idx_ff;
      node_in       = node_ff;
      path_in       = path_ff;
      first_in      = first_ff;
      prev_right_in = prev_right_ff;
      status_in     = status_ff;
      time_in       = time_ff;
      cur_time_in   = cur_time_ff;
      cur_leaf_in   = cur_leaf_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_fire) begin
               active_in   = csr_count;
               fill_all_in = 1'b0;
               rsp_due_in  = 1'b0;
               fill_idx_in = '0;
               state_in    = S_FILL;
            end else if (req_fire) begin
               time_in = req_ch.new_time;
               if (req_ch.req_type == REQ_RESET_ALL) begin
                  fill_all_in = 1'b1;
                  rsp_due_in  = 1'b1;
                  fill_idx_in = '0;
                  status_in   = STATUS_OK;
                  state_in    = S_FILL;
               end else if (!set_ok) begin
                  status_in = STATUS_IGNORED;
                  state_in  = S_DONE;
               end else begin
                  path_in     = {1'b1, req_ch.leaf_index};
                  cur_time_in = req_ch.new_time;
                  cur_leaf_in = req_ch.leaf_index;
                  first_in    = 1'b1;
                  status_in   = STATUS_OK;
                  state_in    = S_UPD;
               end
            end
         end
         S_FILL: begin
            fill_idx_in = fill_idx_ff + 1'b1;
            if (fill_idx_ff == LAST_LEAF) begin
               node_in  = LAST_LEAF;
               state_in = S_RB_RD;
            end
         end
         S_RB_RD: begin
            state_in = S_RB_WR;
         end
         S_RB_WR: begin
            node_in = node_ff - 1'b1;
            if (node_ff == LEVELS'(1)) begin
               state_in = rsp_due_ff ? S_DONE : S_IDLE;
            end else begin
               state_in = S_RB_RD;
            end
         end
         S_UPD: begin
            first_in      = 1'b0;
            path_in       = path_ff >> 1;
            prev_right_in = path_ff[0];
            if (!first_ff) begin
               cur_time_in = win_time;
               cur_leaf_in = win_leaf;
            end
            if (path_ff == ROOT_NODE) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The root is mirrored in flip-flops so that a response never waits on the memory.
   always_comb begin
      root_time_in = root_time_ff;
      root_leaf_in = root_leaf_ff;
      if (wr_en && (wr_addr == ROOT_NODE)) begin
         root_time_in = wr_data[TIME_BITS-1:0];
         root_leaf_in = wr_data[WORD_BITS-1:TIME_BITS];
      end
   end

   // Output register: loaded when an item finishes and the slot is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_leaf_in   = rsp_leaf_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_none_in   = rsp_none_ff;
      rsp_status_in = rsp_status_ff;
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_leaf_in   = root_leaf_ff;
         rsp_time_in   = root_time_ff;
         rsp_none_in   = (root_time_ff == NEVER);
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // Reset starts the clearing pass: every leaf to never, then a full rebuild.
         state_ff      <= S_FILL;
         active_ff     <= '0;
         fill_all_ff   <= 1'b1;
         rsp_due_ff    <= 1'b0;
         fill_idx_ff   <= '0;
         node_ff       <= '0;
         path_ff       <= '0;
         first_ff      <= 1'b0;
         prev_right_ff <= 1'b0;
         status_ff     <= STATUS_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         fill_all_ff   <= fill_all_in;
         rsp_due_ff    <= rsp_due_in;
         fill_idx_ff   <= fill_idx_in;
         node_ff       <= node_in;
         path_ff       <= path_in;
         first_ff      <= first_in;
         prev_right_ff <= prev_right_in;
         status_ff     <= status_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff       <= time_in;
      cur_time_ff   <= cur_time_in;
      cur_leaf_ff   <= cur_leaf_in;
      root_time_ff  <= root_time_in;
      root_leaf_ff  <= root_leaf_in;
      rsp_leaf_ff   <= rsp_leaf_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_none_ff   <= rsp_none_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.earliest_leaf = rsp_leaf_ff;
   assign rsp_ch.earliest_time = rsp_time_ff;
   assign rsp_ch.none_pending  = rsp_none_ff;
   assign rsp_ch.status        = rsp_status_ff;

   // The update path never writes the node whose sibling it is fetching.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) && wr_en |-> (wr_addr != rd_a_addr))
      else $error("update path writes the node it reads");

   // An accepted register write always starts the leaf sweep.
   assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> (state_ff == S_FILL))
      else $error("register write did not start the leaf sweep");

   // A held response reports none pending exactly when its time is never.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_none_ff == (rsp_time_ff == NEVER)))
      else $error("none_pending disagrees with earliest_time");

   // With nothing pending the tie rule leaves leaf zero at the root.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_none_ff |-> (rsp_leaf_ff == '0))
      else $error("empty tree reports a nonzero leaf");

endmodule
